@@ rtl/core/fpr_pkg.sv @@
// fpr_pkg: shared types, constants and address helper for the frame pixel rotator
// used by rtl/core/frame_pixel_rotator.sv; depends on nothing else
package fpr_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int COORD_W    = 6;
  localparam int SIZE_W     = 7;
  localparam int PIXEL_W    = 32;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(DEPTH);

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [SIZE_W-1:0]  size_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [PIXEL_W-1:0] pixel_t;

  typedef enum logic [1:0] {
    ROT_IDENTITY = 2'd0,
    ROT_CW90     = 2'd1,
    ROT_CCW90    = 2'd2,
    ROT_180      = 2'd3
  } rot_mode_t;

  typedef enum logic [1:0] {
    ERR_OK         = 2'd0,
    ERR_OUTSIDE    = 2'd1,
    ERR_NON_SQUARE = 2'd2
  } err_code_t;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_READ = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_MODE   = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_index_t;

  function automatic addr_t pix_addr(input coord_t x, input coord_t y);
    pix_addr = ADDR_W'(ADDR_W'(y) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(x);
  endfunction

endpackage

@@ rtl/core/frame_pixel_rotator.sv @@
// frame_pixel_rotator: frame store with a rotated read path and size/mode registers
// depends on rtl/core/fpr_pkg.sv
//
// Usage: a request is taken at a rising edge with start high and busy low; busy
// stays low, so a request may be issued in every cycle. A load request writes
// in_pixel_in at (in_pos_x, in_pos_y) when that position lies inside the canvas.
// A read request returns the pixel of the rotated frame at that position and
// whether it differs from the stored pixel at the same place.
// The result sits on the out_ ports for one cycle with out_valid high, the
// cycle after the request edge. Throughput is one request per cycle, set by
// the frame store having one write port and two read ports whose read data
// is registered. The receiver cannot stall the block.
// Configuration writes (canvas width, height, rotation mode) go through the cfg_
// channel, which is always ready; sizes above the maximum are saturated.
// Reset sets width and height to the maximum, identity mode, no result pending;
// the frame store itself is not cleared and no clearing pass is needed.
module frame_pixel_rotator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [5:0]  in_pos_x,
  input  logic [5:0]  in_pos_y,
  input  logic [31:0] in_pixel_in,
  output logic        out_valid,
  output logic [31:0] out_pixel_out,
  output logic        out_differs,
  output logic [1:0]  out_error_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_wdata
);

  fpr_pkg::size_t     width_r, height_r;
  fpr_pkg::rot_mode_t mode_r;

  logic               res_valid_r;
  fpr_pkg::err_code_t res_err_r;
  logic               res_rd_r;
  fpr_pkg::pixel_t    rd_src_r, rd_pos_r;

  fpr_pkg::pixel_t    store [fpr_pkg::DEPTH];

  logic               accept;
  logic               pos_in_canvas;
  logic               non_square;
  fpr_pkg::size_t     src_x_w, src_y_w;
  fpr_pkg::addr_t     pos_addr, src_addr;
  fpr_pkg::err_code_t err_nxt;
  logic               do_write, do_read;
  fpr_pkg::size_t     cfg_sat;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  // configuration registers
  always_comb begin
    cfg_sat = cfg_wdata;
    unique case (fpr_pkg::cfg_index_t'(cfg_index))
      fpr_pkg::CFG_WIDTH: begin
        if (cfg_wdata > fpr_pkg::SIZE_W'(fpr_pkg::MAX_WIDTH)) begin
          cfg_sat = fpr_pkg::SIZE_W'(fpr_pkg::MAX_WIDTH);
        end
      end
      fpr_pkg::CFG_HEIGHT: begin
        if (cfg_wdata > fpr_pkg::SIZE_W'(fpr_pkg::MAX_HEIGHT)) begin
          cfg_sat = fpr_pkg::SIZE_W'(fpr_pkg::MAX_HEIGHT);
        end
      end
      default: cfg_sat = cfg_wdata;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= fpr_pkg::SIZE_W'(fpr_pkg::MAX_WIDTH);
      height_r <= fpr_pkg::SIZE_W'(fpr_pkg::MAX_HEIGHT);
      mode_r   <= fpr_pkg::ROT_IDENTITY;
    end else if (cfg_valid && cfg_ready) begin
      unique case (fpr_pkg::cfg_index_t'(cfg_index))
        fpr_pkg::CFG_WIDTH:  width_r  <= cfg_sat;
        fpr_pkg::CFG_HEIGHT: height_r <= cfg_sat;
        fpr_pkg::CFG_MODE:   mode_r   <= fpr_pkg::rot_mode_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end
  end

  // position checks and source mapping
  assign pos_in_canvas = ({1'b0, in_pos_x} < width_r) && ({1'b0, in_pos_y} < height_r);
  assign non_square = (mode_r == fpr_pkg::ROT_CW90 || mode_r == fpr_pkg::ROT_CCW90)
                      && (width_r != height_r);

  always_comb begin
    src_x_w = {1'b0, in_pos_x};
    src_y_w = {1'b0, in_pos_y};
    unique case (mode_r)
      fpr_pkg::ROT_CW90: begin
        src_x_w = {1'b0, in_pos_y};
        src_y_w = height_r - 7'd1 - {1'b0, in_pos_x};
      end
      fpr_pkg::ROT_CCW90: begin
        src_x_w = width_r - 7'd1 - {1'b0, in_pos_y};
        src_y_w = {1'b0, in_pos_x};
      end
      fpr_pkg::ROT_180: begin
        src_x_w = width_r - 7'd1 - {1'b0, in_pos_x};
        src_y_w = height_r - 7'd1 - {1'b0, in_pos_y};
      end
      default: ;
    endcase
  end

  assign pos_addr = fpr_pkg::pix_addr(in_pos_x, in_pos_y);
  assign src_addr = fpr_pkg::pix_addr(src_x_w[fpr_pkg::COORD_W-1:0],
                                      src_y_w[fpr_pkg::COORD_W-1:0]);

  always_comb begin
    err_nxt  = fpr_pkg::ERR_OK;
    do_write = 1'b0;
    do_read  = 1'b0;
    if (in_kind == fpr_pkg::KIND_LOAD) begin
      if (pos_in_canvas) begin
        do_write = accept;
      end else begin
        err_nxt = fpr_pkg::ERR_OUTSIDE;
      end
    end else if (non_square) begin
      err_nxt = fpr_pkg::ERR_NON_SQUARE;
    end else if (!pos_in_canvas) begin
      err_nxt = fpr_pkg::ERR_OUTSIDE;
    end else begin
      do_read = accept;
    end
  end

  // frame store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (do_write) begin
      store[pos_addr] <= in_pixel_in;
    end
  end

  always_ff @(posedge clk) begin
    if (do_read) begin
      rd_src_r <= store[src_addr];
      rd_pos_r <= store[pos_addr];
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      res_rd_r    <= 1'b0;
    end else begin
      res_valid_r <= accept;
      res_rd_r    <= do_read;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_err_r <= err_nxt;
    end
  end

  assign out_valid      = res_valid_r;
  assign out_pixel_out  = res_rd_r ? rd_src_r : '0;
  assign out_differs    = res_rd_r && (rd_src_r != rd_pos_r);
  assign out_error_code = res_valid_r ? res_err_r : fpr_pkg::ERR_OK;

  // checks
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("request without result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept))
    else $error("result without request");

  a_nonsquare_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error_code == fpr_pkg::ERR_NON_SQUARE)
      |-> $past(in_kind) == fpr_pkg::KIND_READ)
    else $error("non-square error on a load");

  a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    res_rd_r |-> (out_valid && out_error_code == fpr_pkg::ERR_OK))
    else $error("store read on a failed request");

  a_size_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (width_r <= fpr_pkg::SIZE_W'(fpr_pkg::MAX_WIDTH))
      && (height_r <= fpr_pkg::SIZE_W'(fpr_pkg::MAX_HEIGHT)))
    else $error("canvas size above maximum");

endmodule
